// ----- src/svb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the sine voice bank.
// No dependencies; the other files refer to it by scoped names or import it.
package svb_pkg;

  localparam int VOICE_MAX           = 128;
  localparam int VOICE_COUNT_DEFAULT = 120;
  localparam int AUDIO_FS_HZ         = 44100;
  localparam int SINE_TABLE_DEPTH    = 1024;
  localparam int SINE_AW             = $clog2(SINE_TABLE_DEPTH);

  localparam int NOTE_W    = 7;
  localparam int REQ_W     = 2;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_W  = 24;
  localparam int MIX_SHIFT = 28;
  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam logic [CFG_W-1:0] START_FLOOR_RST  = 32'd214748;
  localparam logic [CFG_W-1:0] CUTOFF_LEVEL_RST = 32'd42950;
  localparam logic [CFG_W-1:0] MAX_LEVEL_RST    = 32'd257698038;
  localparam logic [CFG_W-1:0] RISE_RATE_RST    = 32'd4294967;
  localparam logic [CFG_W-1:0] FALL_RATE_RST    = 32'd85899;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_START   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RISING  = 2'd1,
    MODE_FALLING = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_FLOOR  = 3'd0,
    CFG_CUTOFF_LEVEL = 3'd1,
    CFG_MAX_LEVEL    = 3'd2,
    CFG_RISE_RATE    = 3'd3,
    CFG_FALL_RATE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] level;
    logic [1:0]  mode;
  } voice_t;

  typedef logic [31:0]        inc_rom_t  [VOICE_MAX];
  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Note frequencies in millihertz, C0 upward.
  localparam logic [24:0] NOTE_MHZ [VOICE_MAX] = '{
    25'd16350, 25'd17320, 25'd18350, 25'd19450, 25'd20600, 25'd21830, 25'd23120,
    25'd24500, 25'd25960, 25'd27500, 25'd29140, 25'd30870,
    25'd32700, 25'd34650, 25'd36710, 25'd38890, 25'd41200, 25'd43650, 25'd46250,
    25'd49000, 25'd51910, 25'd55000, 25'd58270, 25'd61740,
    25'd65410, 25'd69300, 25'd73420, 25'd77780, 25'd82410, 25'd87310, 25'd92500,
    25'd98000, 25'd103800, 25'd110000, 25'd116500, 25'd123500,
    25'd130800, 25'd138600, 25'd146800, 25'd155600, 25'd164800, 25'd174600,
    25'd185000, 25'd196000, 25'd207700, 25'd220000, 25'd233100, 25'd246900,
    25'd261626, 25'd277183, 25'd293665, 25'd311184, 25'd329628, 25'd349228,
    25'd369994, 25'd391995, 25'd415305, 25'd440000, 25'd466164, 25'd493883,
    25'd523300, 25'd554400, 25'd587300, 25'd622300, 25'd659300, 25'd698500,
    25'd740000, 25'd784000, 25'd830600, 25'd880000, 25'd932300, 25'd987800,
    25'd1047000, 25'd1109000, 25'd1175000, 25'd1245000, 25'd1319000, 25'd1397000,
    25'd1480000, 25'd1568000, 25'd1661000, 25'd1760000, 25'd1865000, 25'd1976000,
    25'd2093000, 25'd2217000, 25'd2349000, 25'd2489000, 25'd2637000, 25'd2794000,
    25'd2960000, 25'd3136000, 25'd3322000, 25'd3520000, 25'd3729000, 25'd3951000,
    25'd4186000, 25'd4435000, 25'd4699000, 25'd4978000, 25'd5274000, 25'd5588000,
    25'd5920000, 25'd6272000, 25'd6645000, 25'd7040000, 25'd7459000, 25'd7902000,
    25'd8372019, 25'd8869845, 25'd9397273, 25'd9956064, 25'd10548083, 25'd11175305,
    25'd11839823, 25'd12543855, 25'd13289752, 25'd14080000, 25'd14917240,
    25'd15804266,
    25'd16744036, 25'd17739688, 25'd18794545, 25'd19912127, 25'd21096164,
    25'd22350607, 25'd23679643, 25'd25087708
  };

  localparam logic [63:0] INC_DIV  = 64'(AUDIO_FS_HZ) * 64'd1000;
  localparam logic [63:0] INC_HALF = 64'(AUDIO_FS_HZ) * 64'd500;

  // Rounded phase step per sample, fraction of a turn in 32 bits.
  function automatic inc_rom_t build_phase_inc();
    inc_rom_t    rom;
    logic [63:0] f;
    for (int v = 0; v < VOICE_MAX; v++) begin
      f      = 64'(NOTE_MHZ[v]);
      rom[v] = 32'(((f << 32) + INC_HALF) / INC_DIV);
    end
    return rom;
  endfunction

  // Quarter-wave odd polynomial in Q30, scaled to Q15.
  function automatic sine_rom_t build_sine_table();
    sine_rom_t   rom;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] m;
    logic [1:0]  q;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t  = (64'(k) << 32) / SINE_TABLE_DEPTH;
      q  = t[31:30];
      r  = t & 64'h3FFF_FFFF;
      u  = q[0] ? (64'h4000_0000 - r) : r;
      u2 = (u * u) >> 30;
      s  = 64'd85569304 - ((u2 * 64'd5026995) >> 30);
      s  = 64'd693598668 - ((u2 * s) >> 30);
      s  = 64'd1686629713 - ((u2 * s) >> 30);
      y  = (u * s) >> 30;
      m  = (y * 64'd32767 + 64'h2000_0000) >> 30;
      if (m > 64'd32767) begin
        m = 64'd32767;
      end
      rom[k] = q[1] ? -$signed(16'(m)) : $signed(16'(m));
    end
    return rom;
  endfunction

  localparam inc_rom_t  PHASE_INC = build_phase_inc();
  localparam sine_rom_t SINE_ROM  = build_sine_table();

endpackage

// ----- src/svb_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the sine voice bank: request in, mixed sample out.
// Depends on svb_pkg for field widths.
interface svb_req_if;
  logic                          valid;
  logic                          ready;
  logic [svb_pkg::REQ_W-1:0]     req_type;
  logic [svb_pkg::NOTE_W-1:0]    note_index;

  modport source (output valid, req_type, note_index, input ready);
  modport sink   (input valid, req_type, note_index, output ready);
endinterface

interface svb_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [svb_pkg::SAMPLE_W-1:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink   (input valid, mixed_sample, output ready);
endinterface

// ----- src/sine_voice_bank_with_envelopes.sv -----
`timescale 1ns / 1ps
// Sine voice bank with exponential envelopes: voice state memory, walk pipeline, mixer.
// Depends on svb_pkg (tables, codes) and svb_if (channel interfaces).
//
//  channel  | dir | payload                    | transfer when
//  ---------+-----+----------------------------+------------------------
//  req      | in  | req_type, note_index       | req.valid && req.ready
//  smp      | out | mixed_sample (Q4.19)       | smp.valid && smp.ready
//  cfg      | in  | cfg_index, cfg_data        | cfg_wr_en
//
// A tick walks the voice memory one entry per cycle through a four-stage
// read/modify/write pipeline; the single memory read port sets the pace.
// Start and release read the entry, then write it back. Synchronous reset clears
// the per-voice valid bits, so every voice reads as zero and idle at once.
// The result register holds a sample until taken; a new request is accepted
// meanwhile, and a tick waits at its end only if that register is still full.
module sine_voice_bank_with_envelopes #(
  parameter int VOICE_COUNT = svb_pkg::VOICE_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  svb_req_if.sink                       req,
  svb_sample_if.source                  smp,
  input  logic                          cfg_wr_en,
  input  logic [svb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int MIX_W  = 49;
  localparam int ACC_W  = MIX_W + $clog2(VOICE_COUNT);
  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICE_COUNT - 1);
  localparam logic signed [ACC_W-1:0] ACC_SMP_MAX = ACC_W'(svb_pkg::SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_SMP_MIN = ACC_W'(svb_pkg::SAMPLE_MIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_WR,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  logic [31:0] start_floor;
  logic [31:0] cutoff_level;
  logic [31:0] max_level;
  logic [31:0] rise_rate;
  logic [31:0] fall_rate;

  // Voice state memory with one valid bit per entry
  svb_pkg::voice_t     vmem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] vvalid;
  svb_pkg::voice_t     mem_q;
  logic                mq_valid;
  logic [VIDX_W-1:0]   rd_addr;
  logic                wr_en;
  logic [VIDX_W-1:0]   wr_addr;
  svb_pkg::voice_t     wr_data;

  logic [VIDX_W-1:0]   rd_idx;
  logic [VIDX_W-1:0]   cmd_idx;
  svb_pkg::mode_t      cmd_mode;

  // Pipeline
  logic                p1_vld;
  logic [VIDX_W-1:0]   p1_idx;
  logic                p2_vld;
  logic [VIDX_W-1:0]   p2_idx;
  logic [31:0]         p2_phase;
  logic [31:0]         p2_level;
  logic [31:0]         p2_l1;
  svb_pkg::mode_t      p2_mode;
  logic                p2_keep;
  logic signed [15:0]  sine_q;
  logic                p3_vld;
  logic [VIDX_W-1:0]   p3_idx;
  logic [31:0]         p3_phase;
  logic [31:0]         p3_l1;
  svb_pkg::mode_t      p3_mode;
  logic                p3_keep;
  logic [31:0]         p3_env;
  logic signed [MIX_W-1:0] p3_mix;
  logic signed [ACC_W-1:0] acc;

  logic signed [svb_pkg::SAMPLE_W-1:0] out_sample;
  logic                out_valid;

  // Stage 1 combinational
  svb_pkg::voice_t     cur;
  svb_pkg::mode_t      s1_mode;
  logic [32:0]         floor_sum;
  logic [31:0]         floor_sat;
  logic [31:0]         s1_l1;
  logic                s1_keep;

  // Stage 2 combinational
  logic [63:0]         env_prod;
  logic signed [32:0]  lvl_s;

  // Stage 3 combinational
  logic [32:0]         rise_sum;
  logic [31:0]         s3_level;
  svb_pkg::mode_t      s3_mode;

  logic signed [ACC_W-1:0] acc_shift;
  logic signed [svb_pkg::SAMPLE_W-1:0] sample_next;
  logic                out_free;
  logic                note_ok;

  assign req.ready        = (state == ST_IDLE);
  assign smp.valid        = out_valid;
  assign smp.mixed_sample = out_sample;

  assign rd_addr  = (state == ST_CMD_RD) ? cmd_idx : rd_idx;
  assign out_free = !out_valid || smp.ready;
  assign note_ok  = (8'(req.note_index) < 8'(VOICE_COUNT));

  // Stage 1: decode the entry, apply the start floor, evaluate the hold tests
  always_comb begin
    cur       = mq_valid ? mem_q : '0;
    floor_sum = {1'b0, cur.level} + {1'b0, start_floor};
    floor_sat = floor_sum[32] ? 32'hFFFF_FFFF : floor_sum[31:0];
    case (cur.mode)
      svb_pkg::MODE_RISING: begin
        s1_mode = svb_pkg::MODE_RISING;
        s1_keep = (cur.level < max_level);
        s1_l1   = (cur.level < start_floor) ? floor_sat : cur.level;
      end
      svb_pkg::MODE_FALLING: begin
        s1_mode = svb_pkg::MODE_FALLING;
        s1_keep = (cur.level > cutoff_level);
        s1_l1   = cur.level;
      end
      default: begin
        s1_mode = svb_pkg::MODE_IDLE;
        s1_keep = 1'b0;
        s1_l1   = cur.level;
      end
    endcase
  end

  // Stage 2: envelope and mix products
  always_comb begin
    env_prod = {32'd0, p2_l1} *
               {32'd0, ((p2_mode == svb_pkg::MODE_RISING) ? rise_rate : fall_rate)};
    lvl_s    = $signed({1'b0, p2_level});
  end

  // Stage 3: final level and mode
  always_comb begin
    rise_sum = {1'b0, p3_l1} + {1'b0, p3_env};
    case (p3_mode)
      svb_pkg::MODE_RISING: begin
        s3_level = p3_keep ? (rise_sum[32] ? 32'hFFFF_FFFF : rise_sum[31:0]) : max_level;
        s3_mode  = p3_keep ? svb_pkg::MODE_RISING : svb_pkg::MODE_IDLE;
      end
      svb_pkg::MODE_FALLING: begin
        s3_level = p3_keep ? (p3_l1 - p3_env) : 32'd0;
        s3_mode  = p3_keep ? svb_pkg::MODE_FALLING : svb_pkg::MODE_IDLE;
      end
      default: begin
        s3_level = p3_l1;
        s3_mode  = svb_pkg::MODE_IDLE;
      end
    endcase
  end

  // Write port: command write-back or pipeline tail, never both
  always_comb begin
    if (state == ST_CMD_WR) begin
      wr_en   = 1'b1;
      wr_addr = cmd_idx;
      wr_data = '{phase: cur.phase, level: cur.level, mode: cmd_mode};
    end else begin
      wr_en   = p3_vld;
      wr_addr = p3_idx;
      wr_data = '{phase: p3_phase, level: s3_level, mode: s3_mode};
    end
  end

  // Scale the sum to Q4.19 (arithmetic shift floors) and saturate
  always_comb begin
    acc_shift = acc >>> svb_pkg::MIX_SHIFT;
    if (acc_shift > ACC_SMP_MAX) begin
      sample_next = svb_pkg::SAMPLE_W'(svb_pkg::SAMPLE_MAX);
    end else if (acc_shift < ACC_SMP_MIN) begin
      sample_next = svb_pkg::SAMPLE_W'(svb_pkg::SAMPLE_MIN);
    end else begin
      sample_next = acc_shift[svb_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= vmem[rd_addr];
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    sine_q   <= svb_pkg::SINE_ROM[cur.phase[31 -: svb_pkg::SINE_AW]];
    p1_idx   <= rd_idx;
    p2_idx   <= p1_idx;
    p2_phase <= cur.phase + svb_pkg::PHASE_INC[svb_pkg::NOTE_W'(p1_idx)];
    p2_level <= cur.level;
    p2_l1    <= s1_l1;
    p2_mode  <= s1_mode;
    p2_keep  <= s1_keep;
    p3_idx   <= p2_idx;
    p3_phase <= p2_phase;
    p3_l1    <= p2_l1;
    p3_mode  <= p2_mode;
    p3_keep  <= p2_keep;
    p3_env   <= env_prod[63:32];
    p3_mix   <= sine_q * lvl_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start_floor  <= svb_pkg::START_FLOOR_RST;
      cutoff_level <= svb_pkg::CUTOFF_LEVEL_RST;
      max_level    <= svb_pkg::MAX_LEVEL_RST;
      rise_rate    <= svb_pkg::RISE_RATE_RST;
      fall_rate    <= svb_pkg::FALL_RATE_RST;
      vvalid       <= '0;
      mq_valid     <= 1'b0;
      rd_idx       <= '0;
      cmd_idx      <= '0;
      cmd_mode     <= svb_pkg::MODE_IDLE;
      p1_vld       <= 1'b0;
      p2_vld       <= 1'b0;
      p3_vld       <= 1'b0;
      acc          <= '0;
      out_valid    <= 1'b0;
      out_sample   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          svb_pkg::CFG_START_FLOOR:  start_floor  <= cfg_data;
          svb_pkg::CFG_CUTOFF_LEVEL: cutoff_level <= cfg_data;
          svb_pkg::CFG_MAX_LEVEL:    max_level    <= cfg_data;
          svb_pkg::CFG_RISE_RATE:    rise_rate    <= cfg_data;
          svb_pkg::CFG_FALL_RATE:    fall_rate    <= cfg_data;
          default: ;
        endcase
      end

      mq_valid <= vvalid[rd_addr];
      if (wr_en) begin
        vvalid[wr_addr] <= 1'b1;
      end

      p1_vld <= (state == ST_WALK);
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      if (p3_vld) begin
        acc <= acc + ACC_W'(p3_mix);
      end

      // in ST_FINISH the result register is reloaded below instead
      if (smp.valid && smp.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            case (req.req_type)
              svb_pkg::REQ_TICK: begin
                rd_idx <= '0;
                acc    <= '0;
                state  <= ST_WALK;
              end
              svb_pkg::REQ_START, svb_pkg::REQ_RELEASE: begin
                cmd_idx  <= VIDX_W'(req.note_index);
                cmd_mode <= (req.req_type == svb_pkg::REQ_START) ?
                            svb_pkg::MODE_RISING : svb_pkg::MODE_FALLING;
                if (note_ok) begin
                  state <= ST_CMD_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CMD_RD: begin
          state <= ST_CMD_WR;
        end
        ST_CMD_WR: begin
          state <= ST_IDLE;
        end
        ST_WALK: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // hold until the last voice has been written back and summed
          if (!p1_vld && !p2_vld && !p3_vld) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_sample <= sample_next;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/svb_sample_checker.sv -----
`timescale 1ns / 1ps
// Sample checker for the sine voice bank: mirrors voice state and registers,
// predicts the mixed sample of every tick and compares it on the sample port.
// Depends on svb_pkg and the channel interfaces of svb_if.
module svb_sample_checker #(
  parameter int VOICES = svb_pkg::VOICE_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  svb_req_if                            req,
  svb_sample_if                         smp,
  input  logic                          cfg_wr_en,
  input  logic [svb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svb_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import svb_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [31:0]         step_rom  [VOICE_MAX];
  logic signed [15:0]  wave_rom  [SINE_TABLE_DEPTH];
  logic [31:0]         phase_acc [VOICE_MAX];
  logic [31:0]         env_level [VOICE_MAX];
  mode_t               env_mode  [VOICE_MAX];
  logic [31:0]         floor_q32, cutoff_q32, ceiling_q32, rise_q32, fall_q32;
  logic [SAMPLE_W-1:0] due_samples [$];

  // Rounded phase step of one note, fraction of a turn per sample.
  function automatic logic [31:0] note_step(input int v);
    logic [63:0] f;
    f = 64'(NOTE_MHZ[v]);
    return 32'(((f << 32) + 64'(AUDIO_FS_HZ) * 500) / (64'(AUDIO_FS_HZ) * 1000));
  endfunction

  // Odd 7th-order quarter-wave polynomial in Q30, scaled to Q15.
  function automatic logic signed [15:0] wave_value(input int k);
    logic [63:0] turn, frac, u, u2, poly, y, mag;
    logic [1:0]  quad;
    turn = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    quad = turn[31:30];
    frac = {34'd0, turn[29:0]};
    u    = quad[0] ? 64'h4000_0000 - frac : frac;
    u2   = (u * u) >> 30;
    poly = 64'd85569304 - ((u2 * 64'd5026995) >> 30);
    poly = 64'd693598668 - ((u2 * poly) >> 30);
    poly = 64'd1686629713 - ((u2 * poly) >> 30);
    y    = (u * poly) >> 30;
    mag  = (y * 64'd32767 + 64'h2000_0000) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -16'(mag) : 16'(mag);
  endfunction

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Mix all voices from the current state, then advance phases and envelopes.
  function automatic logic [SAMPLE_W-1:0] mix_and_advance();
    longint      acc;
    longint      mix;
    int          idx;
    logic [31:0] lvl;
    acc = 0;
    for (int v = 0; v < VOICES; v++) begin
      idx = int'((64'(phase_acc[v]) * SINE_TABLE_DEPTH) >> 32);
      acc += longint'(wave_rom[idx]) * longint'(env_level[v]);
      phase_acc[v] = phase_acc[v] + step_rom[v];
      lvl = env_level[v];
      case (env_mode[v])
        MODE_FALLING: begin
          if (lvl > cutoff_q32) begin
            lvl = lvl - 32'((64'(lvl) * 64'(fall_q32)) >> 32);
          end else begin
            lvl = '0;
            env_mode[v] = MODE_IDLE;
          end
        end
        MODE_RISING: begin
          if (lvl < ceiling_q32) begin
            if (lvl < floor_q32) begin
              lvl = add_clamped(lvl, floor_q32);
            end
            lvl = add_clamped(lvl, 32'((64'(lvl) * 64'(rise_q32)) >> 32));
          end else begin
            lvl = ceiling_q32;
            env_mode[v] = MODE_IDLE;
          end
        end
        default: ;
      endcase
      env_level[v] = lvl;
    end
    // Arithmetic shift floors toward minus infinity.
    mix = acc >>> MIX_SHIFT;
    if (mix > SAMPLE_MAX) begin
      mix = SAMPLE_MAX;
    end
    if (mix < SAMPLE_MIN) begin
      mix = SAMPLE_MIN;
    end
    return mix[SAMPLE_W-1:0];
  endfunction

  initial begin
    for (int v = 0; v < VOICE_MAX; v++) step_rom[v] = note_step(v);
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) wave_rom[k] = wave_value(k);
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      floor_q32   = START_FLOOR_RST;
      cutoff_q32  = CUTOFF_LEVEL_RST;
      ceiling_q32 = MAX_LEVEL_RST;
      rise_q32    = RISE_RATE_RST;
      fall_q32    = FALL_RATE_RST;
      for (int v = 0; v < VOICE_MAX; v++) begin
        phase_acc[v] = '0;
        env_level[v] = '0;
        env_mode[v]  = MODE_IDLE;
      end
      due_samples.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_FLOOR:  floor_q32   = cfg_data;
          CFG_CUTOFF_LEVEL: cutoff_q32  = cfg_data;
          CFG_MAX_LEVEL:    ceiling_q32 = cfg_data;
          CFG_RISE_RATE:    rise_q32    = cfg_data;
          CFG_FALL_RATE:    fall_q32    = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_TICK: due_samples.push_back(mix_and_advance());
          REQ_START, REQ_RELEASE: begin
            // Drop commands for notes beyond the bank.
            if (req.note_index < VOICES) begin
              env_mode[req.note_index] = (req.req_type == REQ_START) ? MODE_RISING
                                                                     : MODE_FALLING;
            end
          end
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        if (due_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: sample %0d arrived with none expected", $time,
                     $signed(smp.mixed_sample));
          end
        end else begin
          want = due_samples.pop_front();
          if (smp.mixed_sample !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mixed_sample expected %0d, got %0d", $time,
                       $signed(want), $signed(smp.mixed_sample));
            end
          end
        end
      end
    end
    outstanding = due_samples.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sine voice bank testbench: clock, reset, request and sample
// drivers, register programming and verdict. Depends on svb_pkg, svb_if and the checker.
module testbench;
  import svb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = VOICE_COUNT_DEFAULT + 40;
  localparam int HOLD_CYCLES   = 1500;
  localparam int NOTE_LAST     = VOICE_COUNT_DEFAULT - 1;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  bit                   tx_idle;
  bit                   rx_idle;
  bit                   rx_hold;

  svb_req_if    req_ch ();
  svb_sample_if smp_ch ();

  sine_voice_bank_with_envelopes DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .smp       (smp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  svb_sample_checker sample_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .smp         (smp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #(64'd12_000_000);
    $display("FAIL");
    $finish;
  end

  // Sample side: random stalls while rx_idle is set, plus a long hold while rx_hold is set.
  initial begin : sample_sink
    int gap;
    smp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0 || rx_hold) begin
        smp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      smp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!smp_ch.valid) @(posedge clk);
    end
  end

  // Offer one request, after a random gap if tx_idle is set, and hold it until the transfer.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] note);
    int gap;
    gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.note_index <= note;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] floor_v, input logic [CFG_W-1:0] cutoff_v,
                              input logic [CFG_W-1:0] ceil_v, input logic [CFG_W-1:0] rise_v,
                              input logic [CFG_W-1:0] fall_v);
    write_reg(CFG_START_FLOOR, floor_v);
    write_reg(CFG_CUTOFF_LEVEL, cutoff_v);
    write_reg(CFG_MAX_LEVEL, ceil_v);
    write_reg(CFG_RISE_RATE, rise_v);
    write_reg(CFG_FALL_RATE, fall_v);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid, wait for every sample, then let a trailing start/release finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly ticks and commands on real notes; a little noise.
  task automatic random_burst(input int count, input int tick_pct);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        send_req(REQ_TICK, NOTE_W'($urandom()));
      end else if (roll < 92) begin
        send_req(($urandom_range(0, 99) < 55) ? REQ_START : REQ_RELEASE,
                 NOTE_W'($urandom_range(0, NOTE_LAST)));
      end else if (roll < 96) begin
        send_req(REQ_UNKNOWN, NOTE_W'($urandom()));
      end else begin
        send_req(($urandom_range(0, 1) == 0) ? REQ_START : REQ_RELEASE,
                 NOTE_W'($urandom_range(VOICE_COUNT_DEFAULT, VOICE_MAX - 1)));
      end
    end
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_START_FLOOR;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_TICK;
    req_ch.note_index   <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values; silent bank first, then edge notes and ignored requests.
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_START, 7'd0);
    send_req(REQ_START, NOTE_W'(NOTE_LAST));
    send_req(REQ_START, 7'd57);
    send_req(REQ_START, 7'd127);
    send_req(REQ_RELEASE, 7'd120);
    send_req(REQ_UNKNOWN, 7'd85);
    send_req(REQ_UNKNOWN, 7'd42);
    send_req(REQ_TICK, 7'd127);
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_RELEASE, 7'd57);
    send_req(REQ_START, 7'd42);
    send_req(REQ_START, 7'd85);
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_RELEASE, 7'd0);
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_RELEASE, NOTE_W'(NOTE_LAST));
    send_req(REQ_START, 7'd57);
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_TICK, 7'd0);
    send_req(REQ_RELEASE, 7'd127);
    send_req(REQ_TICK, 7'd0);
    settle();

    // Fast envelopes so voices reach the clamp and the cutoff within a phase.
    program_regs(32'h0100_0000, 32'h0010_0000, 32'h8000_0000, 32'h4000_0000, 32'h2000_0000);
    random_burst(20, 55);
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    random_burst(140, 55);
    settle();

    // All ones: rising saturates then clamps, falling is silenced at once.
    tx_idle = 1'b0;
    program_regs('1, '1, '1, '1, '1);
    random_burst(110, 50);
    settle();

    // All zeros: rising clamps to zero, falling never moves.
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    program_regs('0, '0, '0, '0, '0);
    random_burst(110, 50);
    settle();

    // Loud voices to push the mix into saturation; no idling on either side.
    tx_idle = 1'b0;
    program_regs(32'h8000_0000, '0, '1, '1, '1);
    random_burst(160, 35);
    settle();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    program_regs(START_FLOOR_RST, CUTOFF_LEVEL_RST, MAX_LEVEL_RST, RISE_RATE_RST,
                 FALL_RATE_RST);
    random_burst(160, 50);
    settle();

    for (int p = 0; p < 3; p++) begin
      tx_idle = (p != 1);
      rx_idle = (p != 2);
      program_regs($urandom() >> $urandom_range(4, 16), $urandom() >> $urandom_range(12, 24),
                   $urandom() >> $urandom_range(0, 4), $urandom() >> $urandom_range(1, 12),
                   $urandom() >> $urandom_range(2, 16));
      random_burst(140, 50);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
